// File: rtl/lrut_pkg.sv
// lrut_pkg: shared types and constants of the LRU translation buffer.
// Used by lrut_cell, lru_tlb_top and lrut_chk; depends on nothing.
`timescale 1ns / 1ps

package lrut_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int OP_W        = 2;
    localparam int PAGE_W      = 8;
    localparam int FRAME_W     = 8;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_INVAL  = 2'd2
    } t_op;

    typedef struct packed {
        logic               valid;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } t_entry;

    typedef struct packed {
        logic              cmp;
        logic              upd;
        t_op               op;
        logic [PAGE_W-1:0] page;
    } t_cell_cmd;

    localparam t_entry ENTRY_EMPTY = '{valid: 1'b0, page: '0, frame: '0};

endpackage

// File: rtl/lrut_cell.sv
// lrut_cell: one slot of the recency-ordered entry row.
// Position in the row is the entry's rank; depends on lrut_pkg.
`timescale 1ns / 1ps

module lrut_cell
    import lrut_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_entry    i_up,
    input  t_entry    i_dn,
    input  logic      i_pre,
    input  logic      i_suf,
    output logic      o_pre,
    output logic      o_suf,
    output logic      o_match,
    output t_entry    o_ent
);

    logic               r_valid;
    logic [PAGE_W-1:0]  r_page;
    logic [FRAME_W-1:0] r_frame;
    logic               r_match;

    assign o_pre   = i_pre | r_match;
    assign o_suf   = i_suf | r_match;
    assign o_match = r_match;
    assign o_ent   = '{valid: r_valid, page: r_page, frame: r_frame};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_cmd.cmp) begin
                r_match <= r_valid && (r_page == i_cmd.page);
            end
            if (i_cmd.upd) begin
                case (i_cmd.op)
                    OP_LOOKUP, OP_INSERT: begin
                        if (o_pre) begin
                            r_valid <= i_up.valid;
                        end
                    end
                    OP_INVAL: begin
                        if (o_suf) begin
                            r_valid <= i_dn.valid;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            case (i_cmd.op)
                OP_LOOKUP, OP_INSERT: begin
                    if (o_pre) begin
                        r_page  <= i_up.page;
                        r_frame <= i_up.frame;
                    end
                end
                OP_INVAL: begin
                    if (o_suf) begin
                        r_page  <= i_dn.page;
                        r_frame <= i_dn.frame;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: rtl/lru_tlb_top.sv
// lru_tlb_top: fully associative page-to-frame buffer with LRU replacement.
// Instantiates a row of lrut_cell; depends on lrut_pkg.
`timescale 1ns / 1ps
//
// Each input beat is a lookup, insert or invalidate and yields one output beat
// carrying a hit flag (page present before the operation) and, on a lookup hit,
// the frame. Entries sit in a row of cells ordered by recency, cell 0 least
// recent. An item goes through accept, parallel tag compare into each
// cell's match register, then the update pass in which match flags ripple
// along the row and the cells shift toward or away from the recent end. A new
// item is taken while the previous result waits on the output register. No
// clearing pass is needed after reset.

module lru_tlb_top
    import lrut_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // page_number[7:0], frame_number[15:8]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // frame_out[7:0]
    output logic [0:0]  m_axis_tuser    // hit[0]
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    t_state             r_state;
    t_op                r_op;
    logic [PAGE_W-1:0]  r_page;
    logic [FRAME_W-1:0] r_frame;
    logic               r_out_valid;
    logic               r_hit;
    logic [FRAME_W-1:0] r_frame_out;

    logic               w_accept;
    logic               w_out_free;
    logic               w_upd;
    logic               w_hit;
    logic [FRAME_W-1:0] w_frame_sel;
    t_entry             w_new;
    t_cell_cmd          w_cmd;
    logic [ENTRIES:0]   w_pre;
    logic [ENTRIES:0]   w_suf;
    logic [ENTRIES-1:0] w_match;
    t_entry             w_ent [ENTRIES];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_upd         = (r_state == S_UPD) && w_out_free;

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_frame_out;
    assign m_axis_tuser[0] = r_hit;

    assign w_hit = |w_match;

    always_comb begin
        w_frame_sel = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            w_frame_sel = w_frame_sel | (w_ent[k].frame & {FRAME_W{w_match[k]}});
        end
    end

    assign w_new = '{valid: 1'b1,
                     page:  r_page,
                     frame: (r_op == OP_INSERT) ? r_frame : w_frame_sel};

    assign w_cmd = '{cmp: (r_state == S_CMP), upd: w_upd, op: r_op, page: r_page};

    assign w_pre[0]       = (r_op == OP_INSERT) && !w_hit;
    assign w_suf[ENTRIES] = 1'b0;

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        t_entry w_up;
        t_entry w_dn;

        if (k == ENTRIES - 1) begin : g_top
            assign w_up = w_new;
        end else begin : g_mid
            assign w_up = w_ent[k+1];
        end

        if (k == 0) begin : g_bot
            assign w_dn = ENTRY_EMPTY;
        end else begin : g_low
            assign w_dn = w_ent[k-1];
        end

        lrut_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_up    (w_up),
            .i_dn    (w_dn),
            .i_pre   (w_pre[k]),
            .i_suf   (w_suf[k+1]),
            .o_pre   (w_pre[k+1]),
            .o_suf   (w_suf[k]),
            .o_match (w_match[k]),
            .o_ent   (w_ent[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= t_op'(s_axis_tuser);
            r_page  <= s_axis_tdata[7:0];
            r_frame <= s_axis_tdata[15:8];
        end
        if (w_upd) begin
            r_hit       <= w_hit;
            r_frame_out <= (r_op == OP_LOOKUP) ? w_frame_sel : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_upd) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/lrut_chk.sv
// lrut_sva: port-level checks of lru_tlb_top, attached by bind.
// Sees only the top-level ports; depends on lru_tlb_top.
`timescale 1ns / 1ps

module lrut_sva (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("output beat dropped or changed while stalled");

    a_frame_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata != 8'd0)) |-> m_axis_tuser[0])
        else $error("frame reported without a hit");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input taken before compare and update finished");

    a_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> ##2 m_axis_tvalid)
        else $error("result missing after accepted beat");

endmodule

bind lru_tlb_top lrut_sva u_lrut_sva (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: verif/lrut_chk.sv
// lrut_chk: stream monitor and result checker for lru_tlb_top.
// Predicts hit and frame per input beat from its own tag/rank model; depends on lrut_pkg.
`timescale 1ns / 1ps

module lrut_chk
    import lrut_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_in_data,    // page_number[7:0], frame_number[15:8]
    input  logic [1:0]  i_in_user,    // operation[1:0]
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_data,   // frame_out[7:0]
    input  logic [0:0]  i_out_user,   // hit[0]
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame_out;
    } t_xlat;

    t_xlat              xlat_q[$];
    logic               tag_valid[ENTRIES];
    logic [PAGE_W-1:0]  tag_page[ENTRIES];
    logic [FRAME_W-1:0] tag_frame[ENTRIES];
    int unsigned        tag_rank[ENTRIES];

    function automatic void promote(int idx);
        int i;
        int unsigned r;
        r = tag_rank[idx];
        for (i = 0; i < ENTRIES; i++) begin
            if (tag_rank[i] > r) begin
                tag_rank[i] = tag_rank[i] - 1;
            end
        end
        tag_rank[idx] = ENTRIES - 1;
    endfunction

    function automatic void demote(int idx);
        int i;
        int unsigned r;
        r = tag_rank[idx];
        for (i = 0; i < ENTRIES; i++) begin
            if (tag_rank[i] < r) begin
                tag_rank[i] = tag_rank[i] + 1;
            end
        end
        tag_rank[idx] = 0;
    endfunction

    function automatic t_xlat translate(logic [OP_W-1:0] op, logic [PAGE_W-1:0] page,
                                        logic [FRAME_W-1:0] frame);
        int i;
        int idx;
        t_xlat res;
        idx = -1;
        for (i = 0; i < ENTRIES; i++) begin
            if (idx < 0 && tag_valid[i] && tag_page[i] == page) begin
                idx = i;
            end
        end
        res.hit       = (idx >= 0);
        res.frame_out = '0;
        case (op)
            OP_LOOKUP: begin
                if (idx >= 0) begin
                    res.frame_out = tag_frame[idx];
                    promote(idx);
                end
            end
            OP_INSERT: begin
                if (idx < 0) begin
                    idx = 0;
                    for (i = ENTRIES - 1; i >= 0; i--) begin
                        if (tag_rank[i] == 0) begin
                            idx = i;
                        end
                    end
                    tag_valid[idx] = 1'b1;
                    tag_page[idx]  = page;
                end
                tag_frame[idx] = frame;
                promote(idx);
            end
            OP_INVAL: begin
                if (idx >= 0) begin
                    tag_valid[idx] = 1'b0;
                    tag_page[idx]  = '0;
                    tag_frame[idx] = '0;
                    demote(idx);
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_xlat exp_x;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                tag_valid[i] = 1'b0;
                tag_page[i]  = '0;
                tag_frame[i] = '0;
                tag_rank[i]  = i;
            end
            xlat_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (xlat_q.size() == 0) begin
                    $error("result beat with no pending lookup: hit %0d frame_out 0x%02h",
                           i_out_user[0], i_out_data);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    exp_x = xlat_q.pop_front();
                    if (i_out_user[0] !== exp_x.hit) begin
                        $error("hit: expected %0d, got %0d", exp_x.hit, i_out_user[0]);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_out_data !== exp_x.frame_out) begin
                        $error("frame_out: expected 0x%02h, got 0x%02h",
                               exp_x.frame_out, i_out_data);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                xlat_q.push_back(translate(i_in_user, i_in_data[7:0], i_in_data[15:8]));
            end
        end
        o_pending = xlat_q.size();
    end

endmodule

// File: verif/tb_lru_tlb_top.sv
// tb_lru_tlb_top: stimulus and verdict for lru_tlb_top.
// Drives directed and random lookup/insert/invalidate and unused-code beats; checking lives in lrut_chk.
`timescale 1ns / 1ps

module tb_lru_tlb_top;
    import lrut_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 175;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    int          fail_count;
    int          pending;
    int          src_idle_pct;
    int          snk_stall_pct;
    logic [7:0]  pool_base;

    lru_tlb_top #(.ENTRIES(ENTRIES_DEF)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lrut_chk #(.ENTRIES(ENTRIES_DEF)) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    task automatic send_beat(logic [OP_W-1:0] op, logic [PAGE_W-1:0] page,
                             logic [FRAME_W-1:0] frame);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {frame, page};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        logic [OP_W-1:0]   op;
        logic [PAGE_W-1:0] page;
        int unsigned       sel;
        sel = $urandom_range(0, 99);
        if (sel < 48) begin
            op = OP_LOOKUP;
        end else if (sel < 78) begin
            op = OP_INSERT;
        end else if (sel < 97) begin
            op = OP_INVAL;
        end else begin
            op = OP_UNUSED;
        end
        if ($urandom_range(0, 99) < 80) begin
            page = pool_base + 8'($urandom_range(0, 23));
        end else begin
            page = 8'($urandom);
        end
        send_beat(op, page, 8'($urandom));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        int n;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_LOOKUP;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        pool_base     = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty buffer, extremes, in-place insert, double invalidate, unused code
        send_beat(OP_LOOKUP, 8'h00, 8'h00);
        send_beat(OP_INSERT, 8'h00, 8'hFF);
        send_beat(OP_INSERT, 8'hFF, 8'h00);
        send_beat(OP_LOOKUP, 8'h00, 8'h5A);
        send_beat(OP_LOOKUP, 8'hFF, 8'hFF);
        send_beat(OP_INSERT, 8'h00, 8'hA5);
        send_beat(OP_LOOKUP, 8'h00, 8'h00);
        send_beat(OP_INVAL,  8'hFF, 8'hFF);
        send_beat(OP_INVAL,  8'hFF, 8'h00);
        send_beat(OP_LOOKUP, 8'hFF, 8'h00);
        send_beat(OP_UNUSED, 8'h00, 8'hFF);
        send_beat(OP_UNUSED, 8'h4D, 8'hFF);
        for (n = 0; n < 12; n++) begin
            send_beat(OP_INSERT, 8'h10 + 8'(n), 8'($urandom));
        end
        drain();

        for (n = 0; n < 4; n++) begin
            case (n)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 80; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 80; end
                default: begin src_idle_pct = 22; snk_stall_pct = 22; end
            endcase
            pool_base = 8'($urandom);
            repeat (PHASE_ITEMS) send_random();
            drain();
        end

        s_axis_tvalid <= 1'b0;
        n = 0;
        while (pending != 0 && n < 50000) begin
            @(negedge i_clk);
            n++;
        end
        repeat (8) @(negedge i_clk);
        if (pending != 0) begin
            $error("%0d expected results never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
